[rtl/ft12_pkg.sv]
// Shared types and constants of the FT1.2 frame builder.
package ft12_pkg;

    localparam logic [7:0] START_BYTE  = 8'h68;
    localparam logic [7:0] CTRL_FIRST  = 8'h73;
    localparam logic [7:0] CTRL_SECOND = 8'h53;
    localparam logic [7:0] STOP_BYTE   = 8'h16;
    localparam logic [7:0] ACK_BYTE    = 8'hE5;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // one classified payload byte
    typedef struct packed {
        logic       first;  // opens a frame: header goes out ahead of it
        logic       last;   // closes a frame: trailer follows it
        logic       ack;    // acknowledge byte after the stop byte
        logic [7:0] hdr;    // length field, L+1
        logic [7:0] ctrl;   // control byte of this frame
        logic [7:0] data;   // payload byte
        logic [7:0] sum;    // checksum including this byte
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    typedef enum logic [3:0] {
        PH_NEW,
        PH_START0,
        PH_LEN0,
        PH_LEN1,
        PH_START1,
        PH_CTRL,
        PH_DATA,
        PH_SUM,
        PH_STOP,
        PH_ACK
    } t_phase;

endpackage

[rtl/ft12_front.sv]
// Front end: accepts payload bytes, tracks frame state, builds commands.
module ft12_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_payload_byte,
    input  logic [7:0]            i_payload_length,
    input  logic                  i_append_ack,
    input  ft12_pkg::t_fifo_status i_fifo_status,
    output logic                  o_push,
    output ft12_pkg::t_cmd        o_cmd
);

    logic       r_toggle;
    logic [7:0] r_bytes_left;
    logic [7:0] r_running_sum;
    logic       n_toggle;
    logic [7:0] n_bytes_left;
    logic [7:0] n_running_sum;

    logic       w_first;
    logic [7:0] w_len;
    logic [7:0] w_ctrl;
    logic [7:0] w_base;
    logic [7:0] w_left;
    logic [7:0] w_sum;
    logic [7:0] w_left_next;

    assign o_in_ready = !i_fifo_status.full;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        w_first     = (r_bytes_left == 8'd0);
        w_len       = (i_payload_length == 8'd0) ? 8'd1 : i_payload_length;
        w_ctrl      = r_toggle ? ft12_pkg::CTRL_SECOND : ft12_pkg::CTRL_FIRST;
        w_base      = w_first ? w_ctrl : r_running_sum;
        w_left      = w_first ? w_len : r_bytes_left;
        w_sum       = w_base + i_payload_byte;
        w_left_next = w_left - 8'd1;

        o_cmd.first = w_first;
        o_cmd.last  = (w_left_next == 8'd0);
        o_cmd.ack   = i_append_ack;
        o_cmd.hdr   = w_len + 8'd1;
        o_cmd.ctrl  = w_ctrl;
        o_cmd.data  = i_payload_byte;
        o_cmd.sum   = w_sum;

        n_toggle      = r_toggle;
        n_bytes_left  = r_bytes_left;
        n_running_sum = r_running_sum;
        if (o_push) begin
            n_toggle      = r_toggle ^ w_first;
            n_bytes_left  = w_left_next;
            n_running_sum = o_cmd.last ? 8'd0 : w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toggle      <= 1'b0;
            r_bytes_left  <= 8'd0;
            r_running_sum <= 8'd0;
        end else begin
            r_toggle      <= n_toggle;
            r_bytes_left  <= n_bytes_left;
            r_running_sum <= n_running_sum;
        end
    end

endmodule

[rtl/ft12_cmd_fifo.sv]
// Short command queue between front and back ends.
module ft12_cmd_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ft12_pkg::t_cmd         i_cmd,
    input  logic                   i_pop,
    output ft12_pkg::t_cmd         o_cmd,
    output ft12_pkg::t_fifo_status o_status
);

    localparam logic [ft12_pkg::QPTR_W-1:0] LAST_PTR =
        ft12_pkg::QPTR_W'(ft12_pkg::QUEUE_DEPTH - 1);
    localparam logic [ft12_pkg::QCNT_W-1:0] FULL_CNT =
        ft12_pkg::QCNT_W'(ft12_pkg::QUEUE_DEPTH);

    ft12_pkg::t_cmd r_mem [ft12_pkg::QUEUE_DEPTH];
    logic [ft12_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [ft12_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [ft12_pkg::QCNT_W-1:0] r_count;
    logic [ft12_pkg::QPTR_W-1:0] n_wr_ptr;
    logic [ft12_pkg::QPTR_W-1:0] n_rd_ptr;
    logic [ft12_pkg::QCNT_W-1:0] n_count;
    logic w_push;
    logic w_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign o_cmd          = r_mem[r_rd_ptr];

    always_comb begin
        w_push   = i_push && !o_status.full;
        w_pop    = i_pop && !o_status.empty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[rtl/ft12_back.sv]
// Back end: sequences header, payload and trailer bytes onto the line.
module ft12_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ft12_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_line_byte,
    output logic           o_frame_end
);

    ft12_pkg::t_phase r_phase;
    ft12_pkg::t_phase n_phase;
    ft12_pkg::t_phase w_cur;

    logic       r_out_valid;
    logic [7:0] r_line_byte;
    logic       r_frame_end;
    logic       w_slot;
    logic       w_step;
    logic [7:0] w_byte;
    logic       w_end;

    assign o_out_valid = r_out_valid;
    assign o_line_byte = r_line_byte;
    assign o_frame_end = r_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ft12_pkg::PH_NEW;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        w_slot    = !r_out_valid || i_out_ready;
        w_cur     = r_phase;
        if (r_phase == ft12_pkg::PH_NEW) begin
            w_cur = i_cmd.first ? ft12_pkg::PH_START0 : ft12_pkg::PH_DATA;
        end
        n_phase   = r_phase;
        w_step    = 1'b0;
        o_cmd_pop = 1'b0;
        w_byte    = 8'd0;
        w_end     = 1'b0;
        if (i_cmd_valid && w_slot) begin
            w_step = 1'b1;
            unique case (w_cur)
                ft12_pkg::PH_START0: begin
                    w_byte  = ft12_pkg::START_BYTE;
                    n_phase = ft12_pkg::PH_LEN0;
                end
                ft12_pkg::PH_LEN0: begin
                    w_byte  = i_cmd.hdr;
                    n_phase = ft12_pkg::PH_LEN1;
                end
                ft12_pkg::PH_LEN1: begin
                    w_byte  = i_cmd.hdr;
                    n_phase = ft12_pkg::PH_START1;
                end
                ft12_pkg::PH_START1: begin
                    w_byte  = ft12_pkg::START_BYTE;
                    n_phase = ft12_pkg::PH_CTRL;
                end
                ft12_pkg::PH_CTRL: begin
                    w_byte  = i_cmd.ctrl;
                    n_phase = ft12_pkg::PH_DATA;
                end
                ft12_pkg::PH_DATA: begin
                    w_byte = i_cmd.data;
                    if (i_cmd.last) begin
                        n_phase = ft12_pkg::PH_SUM;
                    end else begin
                        n_phase   = ft12_pkg::PH_NEW;
                        o_cmd_pop = 1'b1;
                    end
                end
                ft12_pkg::PH_SUM: begin
                    w_byte  = i_cmd.sum;
                    n_phase = ft12_pkg::PH_STOP;
                end
                ft12_pkg::PH_STOP: begin
                    w_byte = ft12_pkg::STOP_BYTE;
                    if (i_cmd.ack) begin
                        n_phase = ft12_pkg::PH_ACK;
                    end else begin
                        w_end     = 1'b1;
                        n_phase   = ft12_pkg::PH_NEW;
                        o_cmd_pop = 1'b1;
                    end
                end
                ft12_pkg::PH_ACK: begin
                    w_byte    = ft12_pkg::ACK_BYTE;
                    w_end     = 1'b1;
                    n_phase   = ft12_pkg::PH_NEW;
                    o_cmd_pop = 1'b1;
                end
                default: begin
                    w_step  = 1'b0;
                    n_phase = ft12_pkg::PH_NEW;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_slot) begin
            r_out_valid <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot && w_step) begin
            r_line_byte <= w_byte;
            r_frame_end <= w_end;
        end
    end

endmodule

[rtl/ft12_frame_builder_unit.sv]
// Top level of the FT1.2 variable-length frame builder.
// An accepted payload byte passes the command queue, then the line register.
// One line byte per cycle while the queue holds a command and the receiver is ready;
//   a frame's first byte adds 5 header bytes, its last byte 2 or 3 more (sum, stop, ack).
// The 4-entry command queue lets input keep flowing while header/trailer bytes drain.
// Reset (synchronous, active low): queue empty, no frame open, next control 0x73, ack on.
module ft12_frame_builder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // payload byte transactions
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_payload_byte,
    input  logic [7:0] i_payload_length,
    // line byte transactions
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_line_byte,
    output logic       o_frame_end,
    // append_ack register
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data
);

    // Configuration: append_ack. The user must change it only between frames, so the
    // front end can stamp it into each command; the block does not enforce this.
    logic r_append_ack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_append_ack <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_append_ack <= i_cfg_wr_data;
        end
    end

    logic                   w_push;
    logic                   w_pop;
    ft12_pkg::t_cmd         w_cmd_in;
    ft12_pkg::t_cmd         w_cmd_head;
    ft12_pkg::t_fifo_status w_fifo_status;

    // Front: frame tracking, length/control/checksum per payload byte.
    ft12_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_payload_byte   (i_payload_byte),
        .i_payload_length (i_payload_length),
        .i_append_ack     (r_append_ack),
        .i_fifo_status    (w_fifo_status),
        .o_push           (w_push),
        .o_cmd            (w_cmd_in)
    );

    // Queue: decouples input acceptance from header/trailer bursts.
    ft12_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd_in),
        .i_pop    (w_pop),
        .o_cmd    (w_cmd_head),
        .o_status (w_fifo_status)
    );

    // Back: byte sequencer feeding the output register.
    ft12_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_head),
        .i_cmd_valid (!w_fifo_status.empty),
        .o_cmd_pop   (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_line_byte (o_line_byte),
        .o_frame_end (o_frame_end)
    );

    // The closing byte of a frame is always the stop or acknowledge byte.
    a_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |->
            (o_line_byte == ft12_pkg::STOP_BYTE || o_line_byte == ft12_pkg::ACK_BYTE))
        else $error("frame_end on a byte that is neither stop nor ack");

    // A frame may close on the stop byte only with acknowledge turned off.
    a_stop_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end && o_line_byte == ft12_pkg::STOP_BYTE) |->
            !r_append_ack)
        else $error("frame closed on stop byte while ack is enabled");

    // Input back-pressure comes only from a full queue.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> w_fifo_status.full)
        else $error("input stalled with room in the queue");

    // The back end never pops an empty queue.
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo_status.empty)
        else $error("command popped from an empty queue");

endmodule

[dv/tb_ft12_frame_builder_unit.sv]
// Testbench for the FT1.2 frame builder: self-checking frame predictor with random flow control.
`timescale 1ns / 100ps

module tb_ft12_frame_builder_unit;

    // No-progress limit: cycles in which neither channel completes a transaction.
    // Worst normal wait is a random sender gap or a random receiver stall per
    // line byte, plus the queue drain before a register write.
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 110;
    localparam int TAIL_CYCLES  = 16;

    // One line byte as the receiver should see it.
    typedef struct packed {
        logic [7:0] line_byte;
        logic       frame_end;
    } t_line_beat;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] payload_byte;
    logic [7:0] payload_length;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] line_byte;
    logic       frame_end;
    logic       cfg_wr_en;
    logic       cfg_wr_data;

    // Predictor state: mirrors the block's frame bookkeeping.
    logic       ctrl_toggle;      // 0: next control byte is 0x73, 1: 0x53
    logic [7:0] bytes_remaining;  // payload bytes still owed to the open frame; 0 = between frames
    logic [7:0] frame_sum;        // running checksum of control + payload
    logic       ack_enable;       // shadow of the append_ack register

    t_line_beat line_expect_q[$];

    // Flow-control knobs: a "steady" side never idles, giving stretches of full rate.
    logic tx_steady;
    logic rx_steady;
    int   rx_stall;

    int err_count;
    int items_sent;
    int frames_started;
    int lines_checked;
    int cfg_writes;
    int idle_cycles;

    always #4 clk = ~clk;

    ft12_frame_builder_unit i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_payload_byte   (payload_byte),
        .i_payload_length (payload_length),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_line_byte      (line_byte),
        .o_frame_end      (frame_end),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data)
    );

    function automatic void push_line(input logic [7:0] b, input logic last);
        t_line_beat beat;
        beat.line_byte = b;
        beat.frame_end = last;
        line_expect_q.push_back(beat);
    endfunction

    // Expected line bytes for one accepted payload byte. A byte arriving while no
    // frame is open opens one: header first, length taken from this transaction
    // only (zero is promoted to one). The byte that closes the frame drags the
    // checksum, stop byte and, if enabled, the ack byte behind it.
    function automatic void predict_frame_bytes(input logic [7:0] data,
                                                input logic [7:0] len);
        logic [7:0] eff_len;
        logic [7:0] hdr;
        logic [7:0] ctrl;
        if (bytes_remaining == 8'd0) begin
            eff_len = (len == 8'd0) ? 8'd1 : len;
            hdr     = eff_len + 8'd1;  // wraps to 0x00 for length 255
            ctrl    = ctrl_toggle ? ft12_pkg::CTRL_SECOND : ft12_pkg::CTRL_FIRST;
            ctrl_toggle = ~ctrl_toggle;
            push_line(ft12_pkg::START_BYTE, 1'b0);
            push_line(hdr, 1'b0);
            push_line(hdr, 1'b0);
            push_line(ft12_pkg::START_BYTE, 1'b0);
            push_line(ctrl, 1'b0);
            frame_sum       = ctrl;
            bytes_remaining = eff_len;
            frames_started++;
        end
        push_line(data, 1'b0);
        frame_sum       = frame_sum + data;
        bytes_remaining = bytes_remaining - 8'd1;
        if (bytes_remaining == 8'd0) begin
            push_line(frame_sum, 1'b0);
            if (ack_enable) begin
                push_line(ft12_pkg::STOP_BYTE, 1'b0);
                push_line(ft12_pkg::ACK_BYTE, 1'b1);
            end else begin
                push_line(ft12_pkg::STOP_BYTE, 1'b1);
            end
            frame_sum = 8'd0;
        end
    endfunction

    // Sends one payload transaction. Valid is left high after acceptance; the next
    // call either lowers it for a gap or reuses it for a back-to-back transaction,
    // so valid never gets two assignments in one time step.
    task automatic send_payload(input logic [7:0] data, input logic [7:0] len);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        payload_byte   <= data;
        payload_length <= len;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_frame_bytes(data, len);
        items_sent++;
    endtask

    // Register write, only between frames and with nothing left in flight.
    task automatic set_ack_enable(input logic value);
        in_valid <= 1'b0;
        while (line_expect_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        ack_enable = value;
        cfg_writes++;
    endtask

    // Whole frame of random content; later length fields carry junk on purpose.
    task automatic send_random_frame(input logic [7:0] len);
        int n;
        n = (len == 8'd0) ? 1 : int'(len);
        send_payload(8'($urandom), len);
        for (int i = 1; i < n; i++) begin
            if (i % 32 == 0) tx_steady = ($urandom_range(0, 2) == 0);
            send_payload(8'($urandom), 8'($urandom));
        end
    endtask

    // Reset value of append_ack (on), minimum lengths, zero-length promotion and
    // payload extremes.
    task automatic test_short_frames;
        send_payload(8'h00, 8'd1);
        send_payload(8'hFF, 8'd0);
        send_payload(8'hFF, 8'd2);
        send_payload(8'hFF, 8'd0);
    endtask

    // Length field on middle and last bytes must not disturb the open frame.
    task automatic test_length_ignored_midframe;
        send_payload(8'h55, 8'd4);
        send_payload(8'hAA, 8'd0);
        send_payload(8'h01, 8'd255);
        send_payload(8'h80, 8'hAA);
    endtask

    // Frames without the trailing ack byte, then back to the default.
    task automatic test_ack_disabled;
        set_ack_enable(1'b0);
        send_payload(8'h12, 8'd1);
        send_payload(8'hED, 8'd1);
        send_payload(8'h00, 8'd3);
        send_payload(8'h7F, 8'd1);
        send_payload(8'hFE, 8'd0);
        set_ack_enable(1'b1);
    endtask

    // Checksum wraps several times over a run of all-ones bytes, at full rate.
    task automatic test_sum_wrap;
        tx_steady = 1'b1;
        send_payload(8'hFF, 8'd6);
        for (int i = 1; i < 6; i++) send_payload(8'hFF, 8'h55);
        tx_steady = 1'b0;
    endtask

    // Longest frame: length 255 puts 0x00 in both length header bytes.
    task automatic test_max_length_frame;
        set_ack_enable(1'($urandom_range(0, 1)));
        tx_steady = 1'b0;
        send_random_frame(8'd255);
    endtask

    // Random frames, mostly short, with register changes between some of them.
    task automatic test_random_frames;
        int sel;
        int stop_at;
        logic [7:0] len;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 8)       len = 8'd0;
            else if (sel < 75) len = 8'($urandom_range(1, 6));
            else               len = 8'($urandom_range(7, 24));
            tx_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) set_ack_enable(1'($urandom_range(0, 1)));
            send_random_frame(len);
        end
    endtask

    // Receiver: checks every accepted line byte against the oldest expectation and
    // draws a fresh stall after each transaction.
    always @(posedge clk) begin : line_check
        t_line_beat want;
        int stall;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_stall  = 0;
        end else if (out_valid && out_ready) begin
            lines_checked++;
            if (line_expect_q.size() == 0) begin
                $display("%0t: unexpected line byte: expected none, actual %02h end %0b",
                         $time, line_byte, frame_end);
                err_count++;
            end else begin
                want = line_expect_q.pop_front();
                if (line_byte !== want.line_byte) begin
                    $display("%0t: line_byte mismatch: expected %02h, actual %02h",
                             $time, want.line_byte, line_byte);
                    err_count++;
                end
                if (frame_end !== want.frame_end) begin
                    $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                             $time, want.frame_end, frame_end);
                    err_count++;
                end
            end
            if ($urandom_range(0, 15) == 0) rx_steady = ~rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 14);
            out_ready <= (stall == 0);
            rx_stall  = (stall > 0) ? stall - 1 : 0;
        end else if (rx_stall != 0) begin
            rx_stall = rx_stall - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("** ft12_frame_builder_unit: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        payload_byte   <= 8'h00;
        payload_length <= 8'h00;
        out_ready      <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= 1'b0;
        idle_cycles    <= 0;
        ctrl_toggle     = 1'b0;
        bytes_remaining = 8'd0;
        frame_sum       = 8'd0;
        ack_enable      = 1'b1;
        tx_steady       = 1'b0;
        rx_steady       = 1'b0;
        rx_stall        = 0;
        err_count       = 0;
        items_sent      = 0;
        frames_started  = 0;
        lines_checked   = 0;
        cfg_writes      = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_frames();
        test_length_ignored_midframe();
        test_ack_disabled();
        test_sum_wrap();
        test_max_length_frame();
        test_random_frames();

        // Drain, then give the block room to emit anything it should not.
        in_valid <= 1'b0;
        while (line_expect_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d payload bytes in %0d frames, %0d line bytes, %0d ack writes.",
                 items_sent, frames_started, lines_checked, cfg_writes);
        $display("Lengths 0 to 255, ack on and off, junk length on later bytes, sum wrap.");
        if (err_count == 0) begin
            $display("** ft12_frame_builder_unit: PASSED **");
        end else begin
            $display("** ft12_frame_builder_unit: FAILED **");
        end
        $finish;
    end

endmodule
